/* rtl/core/strapdown_nav_integrator_macros.svh */
`ifndef STRAPDOWN_NAV_INTEGRATOR_MACROS_SVH
`define STRAPDOWN_NAV_INTEGRATOR_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define SNI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define SNI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/sni_pkg.sv */
`timescale 1ns / 1ps

package sni_pkg;

	// Input selector codes
	localparam logic [1:0] FUNC_NAV      = 2'd0;
	localparam logic [1:0] FUNC_LOAD_POS = 2'd1;
	localparam logic [1:0] FUNC_LOAD_VEL = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_TIME_STEP   = 3'd0;
	localparam logic [2:0] REG_GRAVITY     = 3'd1;
	localparam logic [2:0] REG_DECAY       = 3'd2;
	localparam logic [2:0] REG_ZERO_BAND   = 3'd3;
	localparam logic [2:0] REG_STILL_THR   = 3'd4;

	// Configuration reset values
	localparam logic [31:0] RST_TIME_STEP = 32'd4294967;
	localparam logic [22:0] RST_GRAVITY   = 23'd642908;
	localparam logic [15:0] RST_DECAY     = 16'd62259;
	localparam logic [31:0] RST_ZERO_BAND = 32'd4294967;
	localparam logic [31:0] RST_STILL_THR = 32'd218453;

	// Unity in Q4.28 for the rotation diagonal
	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

	// Action taken on the registered product
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_QSTORE,
		ACT_LOAD,
		ACT_ADD,
		ACT_ADD24,
		ACT_FIN_WA,
		ACT_FIN_V,
		ACT_FIN_POS
	} act_t;

	typedef struct packed {
		act_t       act;
		logic [3:0] idx;
	} op_t;

	// First and second quaternion component of each product
	function automatic logic [1:0] qsel_a(input logic [3:0] k);
		logic [1:0] r;
		unique case (k)
			4'd0:    r = 2'd2;
			4'd1:    r = 2'd3;
			4'd2:    r = 2'd1;
			4'd3:    r = 2'd0;
			4'd4:    r = 2'd1;
			4'd5:    r = 2'd0;
			4'd6:    r = 2'd2;
			4'd7:    r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] qsel_b(input logic [3:0] k);
		logic [1:0] r;
		unique case (k)
			4'd0:    r = 2'd2;
			4'd1:    r = 2'd3;
			4'd2:    r = 2'd2;
			4'd3:    r = 2'd3;
			4'd4:    r = 2'd3;
			4'd5:    r = 2'd2;
			4'd6:    r = 2'd3;
			4'd7:    r = 2'd1;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// Saturate to 26 bit signed
	function automatic logic [25:0] sat26(input logic signed [55:0] x);
		logic [25:0] r;
		if (x > 56'sd33554431)
			r = 26'h1FFFFFF;
		else if (x < -56'sd33554432)
			r = 26'h2000000;
		else
			r = x[25:0];
		return r;
	endfunction

	// Saturate to 48 bit signed
	function automatic logic [47:0] sat48(input logic signed [49:0] x);
		logic [47:0] r;
		if (x > 50'sh00007FFFFFFFFFFF)
			r = 48'h7FFFFFFFFFFF;
		else if (x < -50'sh0000800000000000)
			r = 48'h800000000000;
		else
			r = x[47:0];
		return r;
	endfunction

endpackage

/* rtl/core/strapdown_nav_integrator.sv */
`timescale 1ns / 1ps
// Strapdown navigation integrator with zero-velocity update. A navigation word
// is taken only when the block is idle; after acceptance one shared 34 x 34
// signed multiplier with an 82 bit accumulator is stepped through 9 quaternion
// products, three rotation rows of three products and a rounding slot each,
// seven slots per axis for velocity and position updates and a drain step,
// and then the result is loaded into the output register.
// Load-position, load-velocity and unused-code words skip these steps and go
// straight to the output register load. The block is ready again in the cycle
// after its result is registered. A finished result waits in the output
// register, so the next input word may be taken while it has not been
// collected yet; a new result waits until the previous one is.
// Configuration writes are applied at once and must be made while idle.

`include "strapdown_nav_integrator_macros.svh"

module strapdown_nav_integrator
	import sni_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
	// gyro_inv_norm, load_x, load_y, load_z
	input  logic [311:0] s_tdata,
	// func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// world_accel_x, world_accel_y, world_accel_z, vel_out_x, vel_out_y,
	// vel_out_z, pos_out_x, pos_out_y, pos_out_z, two zero pad bits
	output logic [367:0] m_tdata,
	// stationary
	output logic         m_tuser
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;
	typedef enum logic [1:0] {PH_QUAT, PH_ROT, PH_AXIS, PH_DRAIN} phase_t;

	state_t state_q;
	phase_t ph_q;
	logic [3:0] ca_q;
	logic [2:0] cb_q;

	// Configuration
	logic [31:0] time_step_q;
	logic [22:0] gravity_q;
	logic [15:0] decay_q;
	logic [31:0] zero_band_q;
	logic [31:0] still_thr_q;

	// Item payload and navigation state
	logic signed [15:0] q_q [4];
	logic signed [23:0] a_q [3];
	logic [47:0] vel_q [3];
	logic [47:0] pos_q [3];
	logic [25:0] wa_q [3];
	logic still_q;
	logic signed [31:0] preg_q [9];
	logic signed [81:0] acc_q;
	logic signed [67:0] prod_s1;
	op_t op_s1;

	logic s_acc;
	op_t op;
	logic signed [33:0] opa, opb;
	logic signed [33:0] rot [3][3];
	logic [1:0] ri;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign ri = ca_q[1:0];

	// Build rotation entries from the stored quaternion products
	always_comb begin
		rot[0][0] = ONE_Q28 - 34'(2 * (34'(preg_q[0]) + 34'(preg_q[1])));
		rot[0][1] = 34'(2 * (34'(preg_q[2]) - 34'(preg_q[3])));
		rot[0][2] = 34'(2 * (34'(preg_q[4]) + 34'(preg_q[5])));
		rot[1][0] = 34'(2 * (34'(preg_q[2]) + 34'(preg_q[3])));
		rot[1][1] = ONE_Q28 - 34'(2 * (34'(preg_q[8]) + 34'(preg_q[1])));
		rot[1][2] = 34'(2 * (34'(preg_q[6]) - 34'(preg_q[7])));
		rot[2][0] = 34'(2 * (34'(preg_q[4]) - 34'(preg_q[5])));
		rot[2][1] = 34'(2 * (34'(preg_q[6]) + 34'(preg_q[7])));
		rot[2][2] = ONE_Q28 - 34'(2 * (34'(preg_q[8]) + 34'(preg_q[0])));
	end

	// Decode the current step into multiplier operands and an action
	always_comb begin
		op.act = ACT_NONE;
		op.idx = ca_q;
		opa = '0;
		opb = '0;
		if (state_q == ST_RUN) begin
			unique case (ph_q)
				PH_QUAT: begin
					opa = 34'(q_q[qsel_a(ca_q)]);
					opb = 34'(q_q[qsel_b(ca_q)]);
					op.act = ACT_QSTORE;
				end
				PH_ROT: begin
					if (cb_q == 3'd3) begin
						op.act = ACT_FIN_WA;
					end else begin
						opa = rot[ri][cb_q[1:0]];
						opb = 34'(a_q[cb_q[1:0]]);
						op.act = (cb_q == 3'd0) ? ACT_LOAD : ACT_ADD;
					end
				end
				PH_AXIS: begin
					unique case (cb_q)
						3'd0: begin
							if (still_q) begin
								opa = $signed({10'd0, vel_q[ri][23:0]});
								opb = $signed({18'd0, decay_q});
							end else begin
								opa = 34'($signed(wa_q[ri]));
								opb = $signed({2'd0, time_step_q});
							end
							op.act = ACT_LOAD;
						end
						3'd1: begin
							if (still_q) begin
								opa = 34'($signed(vel_q[ri][47:24]));
								opb = $signed({18'd0, decay_q});
								op.act = ACT_ADD24;
							end
						end
						3'd2: op.act = ACT_FIN_V;
						3'd4: begin
							opa = $signed({10'd0, vel_q[ri][23:0]});
							opb = $signed({2'd0, time_step_q});
							op.act = ACT_LOAD;
						end
						3'd5: begin
							opa = 34'($signed(vel_q[ri][47:24]));
							opb = $signed({2'd0, time_step_q});
							op.act = ACT_ADD24;
						end
						3'd6: op.act = ACT_FIN_POS;
						default: op.act = ACT_NONE;
					endcase
				end
				default: op.act = ACT_NONE;
			endcase
		end
	end

	// Finishing arithmetic on the accumulator
	logic signed [55:0] wa_sum;
	logic signed [49:0] v_sum, p_sum, zb_ext;
	logic signed [48:0] dec_v;
	logic [1:0] fi;

	assign fi = op_s1.idx[1:0];

	always_comb begin
		wa_sum = 56'($signed(acc_q[81:28])) + 56'($signed({1'b0, acc_q[27]}))
			- ((fi == 2'd2) ? $signed({33'd0, gravity_q}) : 56'sd0);
		v_sum = 50'($signed(vel_q[fi])) + 50'($signed(acc_q[63:16]))
			+ 50'($signed({1'b0, acc_q[15]}));
		dec_v = 49'($signed(acc_q[63:16])) + 49'($signed({1'b0, acc_q[15]}));
		p_sum = 50'($signed(pos_q[fi])) + 50'($signed(acc_q[79:32]))
			+ 50'($signed({1'b0, acc_q[31]}));
		zb_ext = $signed({18'd0, zero_band_q});
	end

	// Multiplier, accumulator and navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1.act <= ACT_NONE;
			op_s1.idx <= '0;
			for (int i = 0; i < 3; i++) begin
				vel_q[i] <= '0;
				pos_q[i] <= '0;
			end
		end else begin
			prod_s1 <= opa * opb;
			op_s1 <= op;
			// take the item and apply loads
			if (s_acc) begin
				for (int i = 0; i < 4; i++)
					q_q[i] <= $signed(s_tdata[16*i +: 16]);
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= $signed(s_tdata[64 + 24*i +: 24]);
					wa_q[i] <= '0;
					if (s_tuser == FUNC_LOAD_POS)
						pos_q[i] <= s_tdata[168 + 48*i +: 48];
					if (s_tuser == FUNC_LOAD_VEL)
						vel_q[i] <= s_tdata[168 + 48*i +: 48];
				end
				still_q <= (s_tuser == FUNC_NAV) && (s_tdata[167:136] > still_thr_q);
			end
			// apply the registered product
			unique case (op_s1.act)
				ACT_QSTORE: preg_q[op_s1.idx] <= prod_s1[31:0];
				ACT_LOAD:   acc_q <= 82'(prod_s1);
				ACT_ADD:    acc_q <= acc_q + 82'(prod_s1);
				ACT_ADD24:  acc_q <= acc_q + $signed({prod_s1[57:0], 24'd0});
				ACT_FIN_WA: wa_q[fi] <= sat26(wa_sum);
				ACT_FIN_V: begin
					if (still_q) begin
						if ((50'(dec_v) < zb_ext) && (50'(dec_v) > -zb_ext))
							vel_q[fi] <= '0;
						else
							vel_q[fi] <= dec_v[47:0];
					end else begin
						vel_q[fi] <= sat48(v_sum);
					end
				end
				ACT_FIN_POS: pos_q[fi] <= sat48(p_sum);
				default: ;
			endcase
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= RST_TIME_STEP;
			gravity_q   <= RST_GRAVITY;
			decay_q     <= RST_DECAY;
			zero_band_q <= RST_ZERO_BAND;
			still_thr_q <= RST_STILL_THR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_GRAVITY:   gravity_q   <= cfg_data[22:0];
				REG_DECAY:     decay_q     <= cfg_data[15:0];
				REG_ZERO_BAND: zero_band_q <= cfg_data;
				REG_STILL_THR: still_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ph_q     <= PH_QUAT;
			ca_q     <= '0;
			cb_q     <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// drop the word once taken, unless a new result replaces it
			if (m_tvalid && m_tready && (state_q != ST_DONE))
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						ph_q <= PH_QUAT;
						ca_q <= '0;
						cb_q <= '0;
						state_q <= (s_tuser == FUNC_NAV) ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					unique case (ph_q)
						PH_QUAT: begin
							if (ca_q == 4'd8) begin
								ph_q <= PH_ROT;
								ca_q <= '0;
							end else begin
								ca_q <= ca_q + 4'd1;
							end
						end
						PH_ROT: begin
							if (cb_q == 3'd3) begin
								cb_q <= '0;
								if (ca_q == 4'd2) begin
									ph_q <= PH_AXIS;
									ca_q <= '0;
								end else begin
									ca_q <= ca_q + 4'd1;
								end
							end else begin
								cb_q <= cb_q + 3'd1;
							end
						end
						PH_AXIS: begin
							if (cb_q == 3'd6) begin
								cb_q <= '0;
								if (ca_q == 4'd2)
									ph_q <= PH_DRAIN;
								else
									ca_q <= ca_q + 4'd1;
							end else begin
								cb_q <= cb_q + 3'd1;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				default: begin
					// hold the result until the output register is free
					if (!m_tvalid || m_tready) begin
						m_tdata <= {2'd0, pos_q[2], pos_q[1], pos_q[0],
							vel_q[2], vel_q[1], vel_q[0], wa_q[2], wa_q[1], wa_q[0]};
						m_tuser <= still_q;
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`SNI_ASSERT_NEXT(a_load_pos, s_acc && (s_tuser == FUNC_LOAD_POS), pos_q[0] == $past(s_tdata[215:168]), "load position not applied")
	`SNI_ASSERT_NEXT(a_load_done, s_acc && (s_tuser != FUNC_NAV), state_q == ST_DONE, "non-navigation word did not finish at once")
	`SNI_ASSERT_SAME(a_axis_range, (state_q == ST_RUN) && (ph_q == PH_AXIS), (ca_q < 4'd3) && (cb_q < 3'd7), "axis sequencer out of range")

endmodule
